FILE: src/bpwq_pkg.sv
// Shared types and constants for the buffer pool with wait queue.
package bpwq_pkg;

    // Width of a buffer or requester identifier and the size of that id space
    localparam int ID_W     = 4;
    localparam int ID_COUNT = 1 << ID_W;

    // Default pool and wait queue depths
    localparam int DEF_NUM_BUFFERS    = 16;
    localparam int DEF_NUM_REQUESTERS = 16;

    // Request kinds carried in the input tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Outcome codes carried in the output tuser
    typedef enum logic [2:0] {
        OUT_GRANTED  = 3'd0,
        OUT_QUEUED   = 3'd1,
        OUT_HANDED   = 3'd2,
        OUT_POOLED   = 3'd3,
        OUT_REJECTED = 3'd4
    } outcome_t;

endpackage

FILE: src/buffer_pool_with_wait_queue.sv
// Buffer pool allocator with a first-in first-out wait queue for requesters.
//
// Each word on the input stream is an allocate or a free request; each one
// produces exactly one result word. The free list and the wait queue are two
// ring buffers held in synchronous memories with a registered read port, so
// a request passes through the states S_IDLE and S_RESP: in S_IDLE the
// accept decides the outcome, updates the heads and counts and issues the
// ring read, and in S_RESP the result register is loaded from the read data
// once the output register is free. A new request is taken as soon as the
// block is back in idle, so none is taken while one is still in S_RESP;
// while a result word waits on a stalled output, one more request is taken
// and the block then holds until the waiting word is taken. The pool is
// empty after reset and is seeded by free requests. The waiting marks reset
// to cleared at once, so no clearing pass is needed.
module buffer_pool_with_wait_queue
    import bpwq_pkg::*;
#(
    parameter int NUM_BUFFERS    = DEF_NUM_BUFFERS,
    parameter int NUM_REQUESTERS = DEF_NUM_REQUESTERS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*ID_W-1:0]     s_tdata,   // [3:0] requester_id, [7:4] buffer_id
    input  logic [0:0]            s_tuser,   // [0] op
    // Result side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*ID_W-1:0]     m_tdata,   // [3:0] granted_buffer, [7:4] notified_requester
    output logic [2:0]            m_tuser    // [2:0] outcome
);

    localparam int FB_AW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int FB_CW = $clog2(NUM_BUFFERS + 1);
    localparam int FB_SW = FB_CW + 1;
    localparam int WQ_AW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int WQ_CW = $clog2(NUM_REQUESTERS + 1);
    localparam int WQ_SW = WQ_CW + 1;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    // Ring memories
    logic [ID_W-1:0] free_mem [NUM_BUFFERS];
    logic [ID_W-1:0] wait_mem [NUM_REQUESTERS];

    state_t              state_reg,      state_next;
    logic [FB_AW-1:0]    free_head_reg,  free_head_next;
    logic [FB_CW-1:0]    free_count_reg, free_count_next;
    logic [WQ_AW-1:0]    wait_head_reg,  wait_head_next;
    logic [WQ_CW-1:0]    wait_count_reg, wait_count_next;
    logic [ID_COUNT-1:0] mark_reg,       mark_next;
    outcome_t            kind_reg,       kind_next;
    logic [ID_W-1:0]     req_reg,        req_next;
    logic [ID_W-1:0]     buf_reg,        buf_next;
    logic                out_valid_reg,  out_valid_next;
    logic [2*ID_W-1:0]   out_data_reg,   out_data_next;
    outcome_t            out_kind_reg,   out_kind_next;

    logic [ID_W-1:0]     free_rd_reg;
    logic [ID_W-1:0]     wait_rd_reg;

    logic                accept;
    logic [ID_W-1:0]     in_req;
    logic [ID_W-1:0]     in_buf;
    logic                req_in_range;
    logic                buf_in_range;
    logic                free_rd_en;
    logic                free_wr_en;
    logic                wait_rd_en;
    logic                wait_wr_en;
    logic [FB_SW-1:0]    free_sum;
    logic [FB_AW-1:0]    free_tail;
    logic [WQ_SW-1:0]    wait_sum;
    logic [WQ_AW-1:0]    wait_tail;
    logic                out_load;

    assign in_req       = s_tdata[ID_W-1:0];
    assign in_buf       = s_tdata[2*ID_W-1:ID_W];
    assign req_in_range = (32'(in_req) < NUM_REQUESTERS);
    assign buf_in_range = (32'(in_buf) < NUM_BUFFERS);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // Tail positions: head plus count, wrapped once
    always_comb
    begin
        free_sum  = FB_SW'(free_head_reg) + FB_SW'(free_count_reg);
        if (free_sum >= FB_SW'(NUM_BUFFERS))
        begin
            free_sum = free_sum - FB_SW'(NUM_BUFFERS);
        end
        free_tail = free_sum[FB_AW-1:0];

        wait_sum  = WQ_SW'(wait_head_reg) + WQ_SW'(wait_count_reg);
        if (wait_sum >= WQ_SW'(NUM_REQUESTERS))
        begin
            wait_sum = wait_sum - WQ_SW'(NUM_REQUESTERS);
        end
        wait_tail = wait_sum[WQ_AW-1:0];
    end

    // Decide the outcome, advance the rings and build the result word
    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        wait_head_next  = wait_head_reg;
        wait_count_next = wait_count_reg;
        mark_next       = mark_reg;
        kind_next       = kind_reg;
        req_next        = req_reg;
        buf_next        = buf_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_kind_next   = out_kind_reg;
        free_rd_en      = 1'b0;
        free_wr_en      = 1'b0;
        wait_rd_en      = 1'b0;
        wait_wr_en      = 1'b0;
        out_load        = 1'b0;

        // Drop the result word once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = in_req;
                    buf_next   = in_buf;
                    state_next = S_RESP;
                    if (s_tuser[0] == OP_ALLOC)
                    begin
                        if (!req_in_range || mark_reg[in_req])
                        begin
                            kind_next = OUT_REJECTED;
                        end
                        else if (free_count_reg != '0)
                        begin
                            kind_next       = OUT_GRANTED;
                            free_rd_en      = 1'b1;
                            free_count_next = free_count_reg - 1'b1;
                            free_head_next  = (free_head_reg == FB_AW'(NUM_BUFFERS - 1))
                                              ? '0 : free_head_reg + 1'b1;
                        end
                        else if (wait_count_reg == WQ_CW'(NUM_REQUESTERS))
                        begin
                            kind_next = OUT_REJECTED;
                        end
                        else
                        begin
                            kind_next         = OUT_QUEUED;
                            wait_wr_en        = 1'b1;
                            wait_count_next   = wait_count_reg + 1'b1;
                            mark_next[in_req] = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!buf_in_range)
                        begin
                            kind_next = OUT_REJECTED;
                        end
                        else if (wait_count_reg != '0)
                        begin
                            kind_next       = OUT_HANDED;
                            wait_rd_en      = 1'b1;
                            wait_count_next = wait_count_reg - 1'b1;
                            wait_head_next  = (wait_head_reg == WQ_AW'(NUM_REQUESTERS - 1))
                                              ? '0 : wait_head_reg + 1'b1;
                        end
                        else if (free_count_reg == FB_CW'(NUM_BUFFERS))
                        begin
                            kind_next = OUT_REJECTED;
                        end
                        else
                        begin
                            kind_next       = OUT_POOLED;
                            free_wr_en      = 1'b1;
                            free_count_next = free_count_reg + 1'b1;
                        end
                    end
                end
            end
            S_RESP:
            begin
                // Load the result once the output register is free
                out_load = !out_valid_reg || m_tready;
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    state_next     = S_IDLE;
                    case (kind_reg)
                        OUT_GRANTED:
                        begin
                            out_data_next = {req_reg, free_rd_reg};
                        end
                        OUT_HANDED:
                        begin
                            out_data_next          = {wait_rd_reg, buf_reg};
                            mark_next[wait_rd_reg] = 1'b0;
                        end
                        default:
                        begin
                            out_data_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Free list ring
    always_ff @(posedge clk)
    begin
        if (free_wr_en)
        begin
            free_mem[free_tail] <= in_buf;
        end
        if (free_rd_en)
        begin
            free_rd_reg <= free_mem[free_head_reg];
        end
    end

    // Wait queue ring
    always_ff @(posedge clk)
    begin
        if (wait_wr_en)
        begin
            wait_mem[wait_tail] <= in_req;
        end
        if (wait_rd_en)
        begin
            wait_rd_reg <= wait_mem[wait_head_reg];
        end
    end

    // Hold control state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= '0;
            free_count_reg <= '0;
            wait_head_reg  <= '0;
            wait_count_reg <= '0;
            mark_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            wait_head_reg  <= wait_head_next;
            wait_count_reg <= wait_count_next;
            mark_reg       <= mark_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        req_reg      <= req_next;
        buf_reg      <= buf_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

endmodule
